@@ rtl/core/lpmd_pkg.sv @@
package lpmd_pkg;

  // Total length values with this bit set are treated as zero
  localparam logic [31:0] LEN_TOP_BIT = 32'h8000_0000;

  typedef enum logic [3:0] {
    PH_LEN  = 4'b0001,
    PH_ID   = 4'b0010,
    PH_BODY = 4'b0100,
    PH_FAIL = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [7:0]  body_byte;
    logic [31:0] message_id;
    logic        body_last;
    logic        length_error;
  } lpmd_res_t;

endpackage

@@ rtl/core/lpmd_parser.sv @@
module lpmd_parser import lpmd_pkg::*; #(
  parameter int LENGTH_BYTES = 4,
  parameter int ID_BYTES     = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] data_byte_i,
  output logic       res_valid_o,
  output lpmd_res_t  res_o
);

  localparam logic [31:0] HDR_LEN  = 32'(LENGTH_BYTES + ID_BYTES);
  localparam logic [1:0]  LEN_LAST = 2'(LENGTH_BYTES - 1);
  localparam logic [1:0]  ID_LAST  = 2'(ID_BYTES - 1);

  phase_e      phase_q, phase_d;
  logic [1:0]  count_q, count_d;
  logic [31:0] length_q, length_d;
  logic [31:0] id_q, id_d;
  logic [30:0] rem_q, rem_d;

  logic [31:0] len_shift;
  logic [31:0] len_eff;
  logic [30:0] rem_dec;

  assign len_shift = {length_q[23:0], data_byte_i};
  assign len_eff   = (len_shift & LEN_TOP_BIT) != 32'd0 ? 32'd0 : len_shift;
  assign rem_dec   = rem_q - 31'd1;

  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    length_d    = length_q;
    id_d        = id_q;
    rem_d       = rem_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (take_i) begin
      unique case (phase_q)
        PH_LEN: begin
          length_d = len_shift;
          count_d  = count_q + 2'd1;
          if (count_q == LEN_LAST) begin
            count_d = 2'd0;
            if (len_eff <= HDR_LEN) begin
              phase_d            = PH_FAIL;
              res_valid_o        = 1'b1;
              res_o.length_error = 1'b1;
            end else begin
              rem_d   = 31'(len_eff - HDR_LEN);
              id_d    = '0;
              phase_d = PH_ID;
            end
          end
        end
        PH_ID: begin
          // id arrives low byte first
          id_d    = id_q | ({24'd0, data_byte_i} << {count_q, 3'b000});
          count_d = count_q + 2'd1;
          if (count_q == ID_LAST) begin
            count_d = 2'd0;
            phase_d = PH_BODY;
          end
        end
        PH_BODY: begin
          rem_d            = rem_dec;
          res_valid_o      = 1'b1;
          res_o.body_byte  = data_byte_i;
          res_o.message_id = id_q;
          res_o.body_last  = (rem_dec == 31'd0);
          if (rem_dec == 31'd0) begin
            phase_d  = PH_LEN;
            count_d  = 2'd0;
            length_d = '0;
          end
        end
        PH_FAIL: begin
          // sticky until reset, bytes are dropped
        end
        default: begin
          phase_d = PH_FAIL;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_LEN;
      count_q  <= '0;
      length_q <= '0;
      id_q     <= '0;
      rem_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      count_q  <= count_d;
      length_q <= length_d;
      id_q     <= id_d;
      rem_q    <= rem_d;
    end
  end

  a_fail_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_FAIL |=> phase_q == PH_FAIL)
    else $error("failed state left without reset");

  a_body_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_BODY |-> rem_q != 31'd0)
    else $error("body phase with no bytes left");

  a_err_from_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.length_error |=> phase_q == PH_FAIL)
    else $error("length error did not enter failed state");

endmodule

@@ rtl/core/lpmd_outreg.sv @@
module lpmd_outreg import lpmd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  lpmd_res_t res_i,
  input  logic      out_stall_i,
  output logic      out_valid_o,
  output lpmd_res_t res_o
);

  logic      valid_q, valid_d;
  lpmd_res_t res_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> !(valid_q && out_stall_i))
    else $error("held result overwritten");

endmodule

@@ rtl/core/length_prefixed_message_deframer_top.sv @@
// A body beat or error result is registered and becomes valid in the cycle after its input beat is accepted.
// Throughput: one input beat per cycle while in_stall_o is low; header beats produce no result, except a length error.
// The single output register is refilled in the cycle it drains, so input stalls only
// while a result sits unread with out_stall_i high.
// Reset clears the parser to length collection and empties the output register; after a
// length error all input beats are dropped until the next reset.
module length_prefixed_message_deframer_top import lpmd_pkg::*; #(
  parameter int LENGTH_BYTES = 4,
  parameter int ID_BYTES     = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  body_byte_o,
  output logic [31:0] message_id_o,
  output logic        body_last_o,
  output logic        length_error_o
);

  logic      take;
  logic      res_valid;
  lpmd_res_t res;
  lpmd_res_t res_out;

  assign in_stall_o = out_valid_o && out_stall_i;
  assign take       = in_valid_i && !in_stall_o;

  lpmd_parser #(
    .LENGTH_BYTES(LENGTH_BYTES),
    .ID_BYTES    (ID_BYTES)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .data_byte_i(data_byte_i),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  lpmd_outreg u_outreg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (res_valid),
    .res_i      (res),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .res_o      (res_out)
  );

  assign body_byte_o    = res_out.body_byte;
  assign message_id_o   = res_out.message_id;
  assign body_last_o    = res_out.body_last;
  assign length_error_o = res_out.length_error;

endmodule
